@@ hw/rtl/ohmap_pkg.sv @@
// ----------------------------------------------------------------------------
// ohmap_pkg
// Shared types and constants for the linear probing hash map.
// ----------------------------------------------------------------------------
package ohmap_pkg;

  localparam int CAPACITY_LOG2_DEF = 10;
  localparam int QUEUE_DEPTH_LOG2  = 1;
  localparam int COUNT_W           = 11;

  localparam logic [63:0] HASH_MULT = 64'd1099511628211;

  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_GET = 1'b1;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_ZERO_KEY  = 3'd5;

  typedef struct packed {
    logic               cmd;
    logic [63:0]        key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] value_out;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

endpackage

@@ hw/rtl/ohmap_front.sv @@
// ----------------------------------------------------------------------------
// ohmap_front
// Input stage: takes requests, flags zero keys and computes the home slot.
// ----------------------------------------------------------------------------
module ohmap_front import ohmap_pkg::*; #(
  parameter int CAPACITY_LOG2 = CAPACITY_LOG2_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     req_valid,
  output logic                                     req_stall,
  input  req_t                                     req,
  input  logic                                     table_ready,
  output logic                                     q_push,
  output logic [1+CAPACITY_LOG2+$bits(req_t)-1:0]  q_data,
  input  logic                                     q_full
);

  localparam int AddrW = CAPACITY_LOG2;
  localparam logic [AddrW-1:0] MultLow = HASH_MULT[AddrW-1:0];

  logic             st_valid;
  logic             st_zero;
  logic [AddrW-1:0] st_home;
  req_t             st_req;
  logic             accept;

  // Only the low bits of the key reach the low bits of the product.
  logic [AddrW-1:0] home;
  assign home = AddrW'(req.key[AddrW-1:0] * MultLow);

  assign q_push    = st_valid && !q_full;
  assign req_stall = !table_ready || (st_valid && q_full);
  assign accept    = req_valid && !req_stall;
  assign q_data    = {st_zero, st_home, st_req};

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else begin
      if (accept) begin
        st_valid <= 1'b1;
        st_zero  <= (req.key == 64'd0);
        st_home  <= home;
        st_req   <= req;
      end else if (q_push) begin
        st_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/ohmap_queue.sv @@
// ----------------------------------------------------------------------------
// ohmap_queue
// Small FIFO that decouples the input stage from the probe engine.
// ----------------------------------------------------------------------------
module ohmap_queue import ohmap_pkg::*; #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] head,
  output logic              empty
);

  localparam int Depth = 1 << QUEUE_DEPTH_LOG2;

  logic [DATA_W-1:0]           mem [Depth];
  logic [QUEUE_DEPTH_LOG2-1:0] wp;
  logic [QUEUE_DEPTH_LOG2-1:0] rp;
  logic [QUEUE_DEPTH_LOG2:0]   cnt;

  assign full  = (cnt == (QUEUE_DEPTH_LOG2+1)'(Depth));
  assign empty = (cnt == '0);
  assign head  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + QUEUE_DEPTH_LOG2'(1);
      end
      if (pop) begin
        rp <= rp + QUEUE_DEPTH_LOG2'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + (QUEUE_DEPTH_LOG2+1)'(1);
      end else if (pop && !push) begin
        cnt <= cnt - (QUEUE_DEPTH_LOG2+1)'(1);
      end
    end
  end

endmodule

@@ hw/rtl/ohmap_back.sv @@
// ----------------------------------------------------------------------------
// ohmap_back
// Probe engine: slot memories, clearing pass, linear probe and result beat.
// ----------------------------------------------------------------------------
module ohmap_back import ohmap_pkg::*; #(
  parameter int CAPACITY_LOG2 = CAPACITY_LOG2_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  output logic                                     table_ready,
  input  logic [1+CAPACITY_LOG2+$bits(req_t)-1:0]  q_head,
  input  logic                                     q_empty,
  output logic                                     q_pop,
  output logic                                     rsp_valid,
  input  logic                                     rsp_stall,
  output rsp_t                                     rsp
);

  localparam int AddrW = CAPACITY_LOG2;
  localparam int CntW  = CAPACITY_LOG2 + 1;
  localparam int ReqW  = $bits(req_t);
  localparam int Slots = 1 << CAPACITY_LOG2;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK
  } state_t;

  state_t state;

  logic [63:0] slot_keys   [Slots];
  logic [31:0] slot_values [Slots];

  logic [AddrW-1:0] clr_idx;
  logic [AddrW-1:0] idx;
  logic [AddrW-1:0] n;
  logic [CntW-1:0]  count;
  req_t             job;

  logic [63:0]      key_rd;
  logic [31:0]      val_rd;
  logic [AddrW-1:0] rd_addr;
  logic [AddrW-1:0] wr_addr;
  logic [63:0]      wr_key;
  logic             key_we;
  logic             val_we;

  req_t             head_req;
  logic [AddrW-1:0] head_home;
  logic             head_zero;
  logic             out_free;
  logic             hit_empty;
  logic             hit_match;
  logic             last_probe;
  logic             rsp_fire;

  assign head_req  = req_t'(q_head[ReqW-1:0]);
  assign head_home = q_head[ReqW +: AddrW];
  assign head_zero = q_head[ReqW+AddrW];

  assign table_ready = (state != S_CLEAR);
  assign out_free    = !rsp_valid || !rsp_stall;
  assign q_pop       = (state == S_IDLE) && !q_empty && out_free;

  assign hit_empty  = (key_rd == 64'd0);
  assign hit_match  = (key_rd == job.key);
  assign last_probe = &n;

  // Raise a result beat on a zero key pop or at the end of a probe.
  assign rsp_fire = (q_pop && head_zero) ||
                    ((state == S_CHECK) && (hit_empty || hit_match || last_probe));

  // In CHECK, read ahead at the next slot so its key is ready when the probe moves on.
  always_comb begin
    if (state == S_CHECK) begin
      rd_addr = idx + AddrW'(1);
    end else begin
      rd_addr = head_home;
    end
  end

  assign key_we  = (state == S_CLEAR) ||
                   ((state == S_CHECK) && hit_empty && (job.cmd == CMD_PUT));
  assign val_we  = (state == S_CHECK) && (hit_empty || hit_match) && (job.cmd == CMD_PUT);
  assign wr_addr = (state == S_CLEAR) ? clr_idx : idx;
  assign wr_key  = (state == S_CLEAR) ? 64'd0 : job.key;

  always_ff @(posedge clk) begin
    if (key_we) begin
      slot_keys[wr_addr] <= wr_key;
    end
    key_rd <= slot_keys[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      slot_values[wr_addr] <= job.value;
    end
    val_rd <= slot_values[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + AddrW'(1);
          if (&clr_idx) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            if (head_zero) begin
              rsp.status          <= ST_ZERO_KEY;
              rsp.value_out       <= '0;
              rsp.entry_count     <= COUNT_W'(count);
            end else begin
              job   <= head_req;
              idx   <= head_home;
              n     <= '0;
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (hit_empty || hit_match) begin
            state         <= S_IDLE;
            if (job.cmd == CMD_PUT) begin
              rsp.value_out <= '0;
              if (hit_match) begin
                rsp.status      <= ST_UPDATED;
                rsp.entry_count <= COUNT_W'(count);
              end else begin
                rsp.status      <= ST_INSERTED;
                count           <= count + CntW'(1);
                rsp.entry_count <= COUNT_W'(count + CntW'(1));
              end
            end else begin
              rsp.entry_count <= COUNT_W'(count);
              if (hit_match) begin
                rsp.status    <= ST_FOUND;
                rsp.value_out <= val_rd;
              end else begin
                rsp.status    <= ST_NOT_FOUND;
                rsp.value_out <= '0;
              end
            end
          end else if (last_probe) begin
            rsp.status      <= ST_FULL;
            rsp.value_out   <= '0;
            rsp.entry_count <= COUNT_W'(count);
            state           <= S_IDLE;
          end else begin
            idx <= idx + AddrW'(1);
            n   <= n + AddrW'(1);
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  // The table never holds more keys than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Slots))
    else $error("occupied count above table size");

  // A full pass can only end on a table with every slot taken.
  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && !hit_empty && !hit_match && last_probe) |-> count == CntW'(Slots))
    else $error("full pass on a table with free slots");

  // An insert grows the count by exactly one.
  a_insert_counts: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && hit_empty && job.cmd == CMD_PUT) |=> count == $past(count) + CntW'(1))
    else $error("insert did not bump count");

  // No result beat leaves during the clearing pass, and no job starts then.
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (!rsp_valid && !q_pop))
    else $error("activity during clearing pass");

  // A probe in flight never has a result beat waiting.
  a_check_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> !rsp_valid)
    else $error("result beat pending during probe");

endmodule

@@ hw/rtl/open_addressing_hash_map.sv @@
// Path: input stage register, queue, probe of p slots (1 .. table size), result beat.
// The probe engine takes a new operation only when done with the last, one probe per cycle
//   through the single read port of the slot memories; zero-key requests need no probe.
// Reset: a clearing pass writes every slot empty, with req_stall held high until it
//   ends; the entry count starts at zero.
// ----------------------------------------------------------------------------
// open_addressing_hash_map
// Key-to-value map with linear probing over a power-of-two slot table.
// ----------------------------------------------------------------------------
module open_addressing_hash_map import ohmap_pkg::*; #(
  parameter int CAPACITY_LOG2 = CAPACITY_LOG2_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int JobW = 1 + CAPACITY_LOG2 + $bits(req_t);

  logic            table_ready;
  logic            q_push;
  logic [JobW-1:0] q_data;
  logic            q_full;
  logic            q_pop;
  logic [JobW-1:0] q_head;
  logic            q_empty;

  ohmap_front #(
    .CAPACITY_LOG2(CAPACITY_LOG2)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .table_ready(table_ready),
    .q_push     (q_push),
    .q_data     (q_data),
    .q_full     (q_full)
  );

  ohmap_queue #(
    .DATA_W(JobW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_data),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  ohmap_back #(
    .CAPACITY_LOG2(CAPACITY_LOG2)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .table_ready(table_ready),
    .q_head     (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule
